@@ rtl/core/glos_pkg.sv @@
package glos_pkg;

   localparam int GridSideDefault = 64;
   localparam int FracBitsDefault = 8;
   localparam int CoordWidth = 14;
   localparam int CellWidth = 9;
   localparam int SideCsrWidth = 7;
   localparam int SideResetValue = 64;

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_SIGHT = 2'd1;
   localparam logic [1:0] MODE_WALK = 2'd2;
   localparam logic [1:0] MODE_RESERVED = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic [CoordWidth-1:0] start_x;
      logic [CoordWidth-1:0] start_y;
      logic [CoordWidth-1:0] end_x;
      logic [CoordWidth-1:0] end_y;
      logic signed [7:0] cell_walkable;
      logic cell_tower;
   } req_type;

   typedef struct packed {
      logic path_clear;
      logic range_error;
   } rsp_type;

endpackage

@@ rtl/core/glos_if.sv @@
interface glos_req_if
   import glos_pkg::*;
   ();
   logic valid;
   logic ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface glos_rsp_if
   import glos_pkg::*;
   ();
   logic valid;
   logic ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/glos_ram.sv @@
module glos_ram #(
   parameter int Width = 9,
   parameter int Depth = 4096
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(Depth)-1:0] wr_addr,
   input logic [Width-1:0] wr_data,
   input logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ rtl/core/glos_div.sv @@
// restoring divider, one quotient bit per cycle
module glos_div
   import glos_pkg::*;
#(
   parameter int Width = 28
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [Width-1:0] dividend,
   input logic [Width-1:0] divisor,
   output logic done,
   output logic [Width-1:0] quotient
);
   localparam int CntWidth = $clog2(Width + 1);

   logic [Width-1:0] quo_ff, quo_in;
   logic [Width-1:0] rem_ff, rem_in;
   logic [Width-1:0] dvs_ff, dvs_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [Width:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, quo_ff[Width-1]} - {1'b0, dvs_ff};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CntWidth'(Width);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[Width]) begin
            rem_in = trial[Width-1:0];
            quo_in = {quo_ff[Width-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[Width-2:0], quo_ff[Width-1]};
            quo_in = {quo_ff[Width-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule

@@ rtl/core/grid_line_of_sight_check_unit.sv @@
// Grid line-of-sight check unit. Holds a GRID_SIDE x GRID_SIDE grid of cells
// (8-bit signed walkable value plus tower flag) in one RAM, uncleared after
// reset: query only cells that were written. A write, an out-of-range item or
// a sight query between identical points answers the cycle after it is taken.
// A sight or walk query checks range, then walks the line from the lower point
// one sample at a time; each sample runs the shared restoring divider for the
// exact line offset (skipped for a walk between identical points), then one
// RAM read and a test of the cell, which a sample in the destination cell
// skips: up to span/step + 1 samples along the stepped axis, step 0.5 cells
// for sight and 90/256 cells for walk. The unit takes one transaction at a
// time; req_ready is high only when idle with no result waiting.
module grid_line_of_sight_check_unit
   import glos_pkg::*;
#(
   parameter int GRID_SIDE = GridSideDefault,
   parameter int FRAC_BITS = FracBitsDefault
) (
   input logic clock,
   input logic reset,
   glos_req_if.sink req,
   glos_rsp_if.source rsp,
   input logic csr_write,
   input logic [SideCsrWidth-1:0] csr_wdata
);
   localparam int IdxW = $clog2(GRID_SIDE);
   localparam int AddrW = 2 * IdxW;
   localparam int CellW = CoordWidth - FRAC_BITS;
   localparam int DivW = 2 * CoordWidth;
   localparam int SideW = $clog2(GRID_SIDE + 1);
   localparam int ClampW = SideCsrWidth + SideW;
   localparam logic [CoordWidth-1:0] SightStep = CoordWidth'(1 << (FRAC_BITS - 1));
   localparam int WalkRaw = (90 * (1 << FRAC_BITS) + 128) / 256;
   localparam logic [CoordWidth-1:0] WalkStep =
      CoordWidth'((WalkRaw == 0) ? 1 : WalkRaw);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SAMPLE = 3'd1;
   localparam logic [2:0] ST_DIV = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_TEST = 3'd4;
   localparam logic [2:0] ST_RESP = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [SideCsrWidth-1:0] side_ff;
   logic walk_ff, walk_in, stepx_ff, stepx_in, neg_ff, neg_in;
   logic [CoordWidth-1:0] u_ff, u_in, u1_ff, u1_in, u2_ff, u2_in, v1_ff, v1_in;
   logic [CoordWidth-1:0] dv_ff, dv_in, v_ff, v_in;
   logic [CellW-1:0] destx_ff, destx_in, desty_ff, desty_in;
   logic [AddrW-1:0] addr_ff, addr_in;
   logic clear_ff, clear_in, err_ff, err_in, rvalid_ff, rvalid_in;

   logic [SideW-1:0] side_use;
   logic start_ok, end_ok;
   logic [CellW-1:0] sxc, syc, exc, eyc, cx, cy;
   logic [CoordWidth-1:0] du, step, cur_v;
   logic [CoordWidth:0] u_next;
   logic div_start, div_done;
   logic [DivW-1:0] quo, num, den;
   logic wr_en;
   logic [AddrW-1:0] wr_addr;
   logic [CellWidth-1:0] rd_data;
   logic last_sample;

   always_comb begin
      if (side_ff < SideCsrWidth'(2)) side_use = SideW'(2);
      else if (ClampW'(side_ff) > ClampW'(GRID_SIDE)) side_use = SideW'(GRID_SIDE);
      else side_use = SideW'(side_ff);
   end

   assign sxc = req.payload.start_x[CoordWidth-1:FRAC_BITS];
   assign syc = req.payload.start_y[CoordWidth-1:FRAC_BITS];
   assign exc = req.payload.end_x[CoordWidth-1:FRAC_BITS];
   assign eyc = req.payload.end_y[CoordWidth-1:FRAC_BITS];
   assign start_ok = (CellW + SideW)'(sxc) < (CellW + SideW)'(side_use)
                  && (CellW + SideW)'(syc) < (CellW + SideW)'(side_use);
   assign end_ok = (CellW + SideW)'(exc) < (CellW + SideW)'(side_use)
                && (CellW + SideW)'(eyc) < (CellW + SideW)'(side_use);

   assign du = u2_ff - u1_ff;
   assign step = walk_ff ? WalkStep : SightStep;
   assign u_next = {1'b0, u_ff} + {1'b0, step};
   assign last_sample = walk_ff ? (u_next > {1'b0, u2_ff}) : (u_next >= {1'b0, u2_ff});

   assign num = DivW'(dv_ff) * DivW'(u_ff - u1_ff) + (neg_ff ? DivW'(du - 1'b1) : '0);
   assign den = DivW'(du);

   always_comb begin
      if (neg_ff) cur_v = v1_ff - quo[CoordWidth-1:0];
      else cur_v = v1_ff + quo[CoordWidth-1:0];
   end

   assign cx = stepx_ff ? u_ff[CoordWidth-1:FRAC_BITS] : v_ff[CoordWidth-1:FRAC_BITS];
   assign cy = stepx_ff ? v_ff[CoordWidth-1:FRAC_BITS] : u_ff[CoordWidth-1:FRAC_BITS];

   glos_div #(.Width(DivW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(num), .divisor(den),
      .done(div_done), .quotient(quo)
   );

   assign wr_en = (state_ff == ST_IDLE) && req.valid && !rvalid_ff
               && (req.payload.mode == MODE_WRITE) && start_ok;
   assign wr_addr = {IdxW'(sxc), IdxW'(syc)};

   glos_ram #(.Width(CellWidth), .Depth(1 << AddrW)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr),
      .wr_data({req.payload.cell_tower, req.payload.cell_walkable}),
      .rd_addr(addr_ff), .rd_data(rd_data)
   );

   assign req.ready = (state_ff == ST_IDLE) && !rvalid_ff;
   assign rsp.valid = rvalid_ff;
   assign rsp.payload.path_clear = clear_ff;
   assign rsp.payload.range_error = err_ff;

   always_comb begin
      logic sx_dir;
      logic [CoordWidth-1:0] a_u, a_v, b_u, b_v;
      logic blocked;
      state_in = state_ff;
      walk_in = walk_ff; stepx_in = stepx_ff; neg_in = neg_ff;
      u_in = u_ff; u1_in = u1_ff; u2_in = u2_ff; v1_in = v1_ff;
      dv_in = dv_ff; v_in = v_ff;
      destx_in = destx_ff; desty_in = desty_ff; addr_in = addr_ff;
      clear_in = clear_ff; err_in = err_ff; rvalid_in = rvalid_ff;
      div_start = 1'b0;
      sx_dir = req.payload.start_x != req.payload.end_x;
      a_u = sx_dir ? req.payload.start_x : req.payload.start_y;
      a_v = sx_dir ? req.payload.start_y : req.payload.start_x;
      b_u = sx_dir ? req.payload.end_x : req.payload.end_y;
      b_v = sx_dir ? req.payload.end_y : req.payload.end_x;
      blocked = walk_ff ? (($signed(rd_data[7:0]) <= 8'sd0) || rd_data[8])
                        : rd_data[7];
      if (rvalid_ff && rsp.ready) rvalid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && !rvalid_ff) begin
               clear_in = 1'b0; err_in = 1'b0;
               case (req.payload.mode)
                  MODE_WRITE: begin
                     clear_in = start_ok; err_in = !start_ok;
                     rvalid_in = 1'b1;
                  end
                  MODE_SIGHT, MODE_WALK: begin
                     if (!start_ok || !end_ok) begin
                        err_in = 1'b1; rvalid_in = 1'b1;
                     end else begin
                        walk_in = req.payload.mode == MODE_WALK;
                        stepx_in = sx_dir;
                        destx_in = exc; desty_in = eyc;
                        if (a_u > b_u) begin
                           u1_in = b_u; u2_in = a_u; v1_in = b_v;
                           neg_in = a_v < b_v;
                           dv_in = (a_v < b_v) ? b_v - a_v : a_v - b_v;
                           u_in = b_u;
                        end else begin
                           u1_in = a_u; u2_in = b_u; v1_in = a_v;
                           neg_in = b_v < a_v;
                           dv_in = (b_v < a_v) ? a_v - b_v : b_v - a_v;
                           u_in = a_u;
                        end
                        clear_in = 1'b1;
                        if (req.payload.mode == MODE_SIGHT && a_u == b_u) begin
                           rvalid_in = 1'b1;
                        end else begin
                           state_in = ST_SAMPLE;
                        end
                     end
                  end
                  default: rvalid_in = 1'b1;
               endcase
            end
         end
         ST_SAMPLE: begin
            if (du == '0) begin
               v_in = v1_ff; state_in = ST_READ;
            end else begin
               div_start = 1'b1; state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               v_in = cur_v; state_in = ST_READ;
            end
         end
         ST_READ: begin
            addr_in = {IdxW'(cx), IdxW'(cy)};
            if (cx == destx_ff && cy == desty_ff) begin
               if (last_sample) begin
                  rvalid_in = 1'b1; state_in = ST_IDLE;
               end else begin
                  u_in = u_next[CoordWidth-1:0]; state_in = ST_SAMPLE;
               end
            end else begin
               state_in = ST_TEST;
            end
         end
         ST_TEST: state_in = ST_RESP;
         ST_RESP: begin
            if (blocked) begin
               clear_in = 1'b0; rvalid_in = 1'b1; state_in = ST_IDLE;
            end else if (last_sample) begin
               rvalid_in = 1'b1; state_in = ST_IDLE;
            end else begin
               u_in = u_next[CoordWidth-1:0]; state_in = ST_SAMPLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      walk_ff <= walk_in; stepx_ff <= stepx_in; neg_ff <= neg_in;
      u_ff <= u_in; u1_ff <= u1_in; u2_ff <= u2_in; v1_ff <= v1_in;
      dv_ff <= dv_in; v_ff <= v_in;
      destx_ff <= destx_in; desty_ff <= desty_in; addr_ff <= addr_in;
      clear_ff <= clear_in; err_ff <= err_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         rvalid_ff <= 1'b0;
         side_ff <= SideCsrWidth'(SideResetValue);
      end else begin
         state_ff <= state_in;
         rvalid_ff <= rvalid_in;
         if (csr_write) side_ff <= csr_wdata;
      end
   end
endmodule
